// ----- rtl/rrq_pkg.sv -----
// ---------------------------------------------------------------------------
// rrq_pkg
// Shared types, constants and index helpers for the round-robin ready queue.
// ---------------------------------------------------------------------------
package rrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PID_W       = 8;
    localparam int REQ_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [REQ_W-1:0] {
        OP_ENQUEUE = 2'd0,
        OP_POP     = 2'd1,
        OP_ROTATE  = 2'd2,
        OP_REMOVE  = 2'd3
    } rrq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } rrq_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_RD,
        S_ROT_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_HEAD_RD,
        S_RESULT
    } rrq_state_t;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic signed [PID_W-1:0] item_pid;
        logic signed [PID_W-1:0] head_pid;
        logic                   head_valid;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rrq_result_t;

    // circular index add, both operands below the depth
    function automatic idx_t rrq_wrap_add(idx_t a, idx_t b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (IDX_W+1)'(QUEUE_DEPTH))
            s = s - (IDX_W+1)'(QUEUE_DEPTH);
        return s[IDX_W-1:0];
    endfunction

    function automatic idx_t rrq_wrap_inc(idx_t a);
        return rrq_wrap_add(a, IDX_W'(1));
    endfunction

    function automatic idx_t rrq_wrap_dec(idx_t a);
        idx_t r;
        if (a == '0)
            r = IDX_W'(QUEUE_DEPTH - 1);
        else
            r = a - IDX_W'(1);
        return r;
    endfunction

endpackage

// ----- rtl/rrq_if.sv -----
// ---------------------------------------------------------------------------
// rrq_req_if / rrq_rsp_if
// Valid/ready channels for requests into and results out of the ready queue.
// ---------------------------------------------------------------------------
interface rrq_req_if;
    import rrq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [PID_W-1:0] pid;

    modport source (output valid, output req_type, output pid, input ready);
    modport sink   (input valid, input req_type, input pid, output ready);
endinterface

interface rrq_rsp_if;
    import rrq_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic signed [PID_W-1:0] item_pid;
    logic signed [PID_W-1:0] head_pid;
    logic                    head_valid;
    logic [COUNT_OUT_W-1:0]  entry_count;

    modport source (
        output valid, output status, output item_pid, output head_pid,
        output head_valid, output entry_count, input ready
    );
    modport sink (
        input valid, input status, input item_pid, input head_pid,
        input head_valid, input entry_count, output ready
    );
endinterface

// ----- rtl/rrq_ram.sv -----
// ---------------------------------------------------------------------------
// rrq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rrq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rrq_rsp_reg.sv -----
// ---------------------------------------------------------------------------
// rrq_rsp_reg
// Result register: holds one finished item until the consumer takes it.
// ---------------------------------------------------------------------------
module rrq_rsp_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  rrq_pkg::rrq_result_t result,
    output logic                free,
    rrq_rsp_if.source           rsp
);
    import rrq_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    rrq_result_t data_reg;

    assign free = !valid_reg || rsp.ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign rsp.valid       = valid_reg;
    assign rsp.status      = data_reg.status;
    assign rsp.item_pid    = data_reg.item_pid;
    assign rsp.head_pid    = data_reg.head_pid;
    assign rsp.head_valid  = data_reg.head_valid;
    assign rsp.entry_count = data_reg.entry_count;

endmodule

// ----- rtl/round_robin_ready_queue.sv -----
// ---------------------------------------------------------------------------
// round_robin_ready_queue
// Circular ready queue of process ids: enqueue, pop, rotate, remove by pid.
// ---------------------------------------------------------------------------
// One request is taken at a time and produces exactly one result item. The
// queue entries live in a single-port-read RAM with registered read data, and
// every RAM access is one step of a small sequencer. Enqueue writes the tail
// as it is accepted; pop and rotate read the head, then pop retires it and
// rotate writes it to the tail. Remove reads and compares each entry up to
// and including the match, then reads and writes each entry behind it to
// close the gap; an absent pid is compared against every entry. A failed
// enqueue or pop, remove on an empty queue and rotate with fewer than two
// entries do no RAM work of their own. Every request ends with a read of the
// new head and a result step. A finished result waits in an output register;
// the next request is accepted while it waits, and the block only stalls at
// the end of that next request.
module round_robin_ready_queue (
    input  logic      clk,
    input  logic      rst_n,
    rrq_req_if.sink   req,
    rrq_rsp_if.source rsp
);
    import rrq_pkg::*;

    rrq_state_t state_reg, state_next;
    idx_t       head_reg, head_next;
    idx_t       tail_reg, tail_next;
    cnt_t       count_reg, count_next;
    idx_t       pos_reg, pos_next;
    rrq_op_t    op_reg, op_next;
    logic [PID_W-1:0] pid_reg, pid_next;
    rrq_status_t status_reg, status_next;
    logic [PID_W-1:0] item_reg, item_next;

    logic             ram_wr_en;
    idx_t             ram_wr_addr;
    logic [PID_W-1:0] ram_wr_data;
    logic             ram_rd_en;
    idx_t             ram_rd_addr;
    logic [PID_W-1:0] ram_rd_data;

    logic        rsp_load;
    logic        rsp_free;
    rrq_result_t result;

    logic    accept;
    rrq_op_t in_op;
    logic    is_full;
    logic    q_empty;
    logic    under_two;
    idx_t    pos_slot;
    idx_t    pos_next_slot;
    logic    pos_is_last;
    logic    match;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign in_op     = rrq_op_t'(req.req_type);

    assign is_full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_empty   = (count_reg == '0);
    assign under_two = (count_reg < CNT_W'(2));

    // logical position to physical slot, measured from the head
    assign pos_slot      = rrq_wrap_add(head_reg, pos_reg);
    assign pos_next_slot = rrq_wrap_add(head_reg, pos_reg + IDX_W'(1));
    assign pos_is_last   = ((CNT_W'(pos_reg) + CNT_W'(1)) >= count_reg);
    assign match         = (ram_rd_data == pid_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_ENQUEUE: state_next = S_HEAD_RD;
                        OP_POP:     state_next = q_empty ? S_HEAD_RD : S_POP_RD;
                        OP_ROTATE:  state_next = under_two ? S_HEAD_RD : S_ROT_WR;
                        OP_REMOVE:  state_next = q_empty ? S_HEAD_RD : S_SCAN_RD;
                        default:    state_next = S_HEAD_RD;
                    endcase
                end
            end
            S_POP_RD:   state_next = S_HEAD_RD;
            S_ROT_WR:   state_next = S_HEAD_RD;
            S_SCAN_RD:  state_next = S_SCAN_CMP;
            S_SCAN_CMP:
            begin
                if (match)
                    state_next = S_SHIFT_RD;
                else if (pos_is_last)
                    state_next = S_HEAD_RD;
                else
                    state_next = S_SCAN_RD;
            end
            S_SHIFT_RD: state_next = pos_is_last ? S_HEAD_RD : S_SHIFT_WR;
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_HEAD_RD:  state_next = S_RESULT;
            S_RESULT:   state_next = rsp_free ? S_IDLE : S_RESULT;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        op_next     = op_reg;
        pid_next    = pid_reg;
        status_next = status_reg;
        item_next   = item_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = tail_reg;
        ram_wr_data = pid_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = head_reg;
        rsp_load    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = in_op;
                    pid_next    = req.pid;
                    status_next = ST_OK;
                    item_next   = '0;
                    pos_next    = '0;
                    case (in_op)
                        OP_ENQUEUE:
                        begin
                            if (is_full)
                                status_next = ST_FULL;
                            else
                            begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = tail_reg;
                                ram_wr_data = req.pid;
                                tail_next   = rrq_wrap_inc(tail_reg);
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        OP_POP:
                        begin
                            if (q_empty)
                                status_next = ST_EMPTY;
                            else
                                ram_rd_en = 1'b1;
                        end
                        OP_ROTATE:
                        begin
                            if (!under_two)
                                ram_rd_en = 1'b1;
                        end
                        OP_REMOVE:
                        begin
                            if (q_empty)
                                status_next = ST_NOT_FOUND;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_POP_RD:
            begin
                item_next  = ram_rd_data;
                head_next  = rrq_wrap_inc(head_reg);
                count_next = count_reg - CNT_W'(1);
            end
            S_ROT_WR:
            begin
                // when full the head and tail share a slot and the write is a no-op
                ram_wr_en   = 1'b1;
                ram_wr_addr = tail_reg;
                ram_wr_data = ram_rd_data;
                head_next   = rrq_wrap_inc(head_reg);
                tail_next   = rrq_wrap_inc(tail_reg);
            end
            S_SCAN_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = pos_slot;
            end
            S_SCAN_CMP:
            begin
                if (match)
                    item_next = pid_reg;
                else if (pos_is_last)
                    status_next = ST_NOT_FOUND;
                else
                    pos_next = pos_reg + IDX_W'(1);
            end
            S_SHIFT_RD:
            begin
                if (pos_is_last)
                begin
                    tail_next  = rrq_wrap_dec(tail_reg);
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_next_slot;
                end
            end
            S_SHIFT_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_slot;
                ram_wr_data = ram_rd_data;
                pos_next    = pos_reg + IDX_W'(1);
            end
            S_HEAD_RD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = head_reg;
            end
            S_RESULT:
            begin
                rsp_load = rsp_free;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.status      = status_reg;
        result.item_pid    = item_reg;
        result.head_pid    = q_empty ? '0 : ram_rd_data;
        result.head_valid  = !q_empty;
        result.entry_count = COUNT_OUT_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        op_reg     <= op_next;
        pid_reg    <= pid_next;
        status_reg <= status_next;
        item_reg   <= item_next;
    end

    rrq_ram #(
        .WIDTH (PID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    rrq_rsp_reg u_rsp (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (rsp_load),
        .result (result),
        .free   (rsp_free),
        .rsp    (rsp)
    );

    // the op register is kept for debug visibility of the request in flight
    logic op_is_remove;
    assign op_is_remove = (op_reg == OP_REMOVE);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_tail_follows_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            ((is_full && (tail_reg == head_reg)) ||
             (!is_full && (tail_reg == rrq_wrap_add(head_reg, IDX_W'(count_reg))))))
        else $error("tail index out of step with head and occupancy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while previous one still in progress");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CNT_W'(1)) ||
             (count_reg == $past(count_reg) - CNT_W'(1))))
        else $error("occupancy moved by more than one");

    a_shift_only_on_remove: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN_RD) || (state_reg == S_SHIFT_WR)) |-> op_is_remove)
        else $error("scan or shift outside a remove");

endmodule
